FILE: rtl/gf2irr_pkg.sv
// Shared constants, state encoding and control/status structs for the GF(2) irreducibility test.
package gf2irr_pkg;

   localparam int POLY_WIDTH = 32;
   // Input word is 32 bits wide, so only the low min(POLY_WIDTH, 32) bits can matter.
   localparam int DATA_W  = (POLY_WIDTH < 32) ? POLY_WIDTH : 32;
   localparam int DEG_W   = $clog2(DATA_W);
   localparam int TRIAL_W = DATA_W / 2 + 1;
   localparam int TDEG_W  = $clog2(DATA_W / 2 + 1);
   localparam int EXP_W   = DEG_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_LOAD,
      ST_DIV,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_input;
      logic deg_shift;
      logic init_trial;
      logic load_div;
      logic div_step;
      logic next_trial;
   } cmd_type;

   typedef struct packed {
      logic p_le1;
      logic msb_set;
      logic div_last;
      logic hit;
      logic last_trial;
   } sts_type;

endpackage

FILE: rtl/gf2irr_dpath.sv
// Datapath: degree scan, trial divisor sequencing and bit-serial shift-and-XOR division.
module gf2irr_dpath
   import gf2irr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] poly_value,
   input  cmd_type     cmd,
   output sts_type     sts
);

   logic [DATA_W-1:0]  poly_ff,  poly_in;
   logic [DATA_W-1:0]  scan_ff,  scan_in;
   logic [DEG_W-1:0]   deg_ff,   deg_in;
   logic [TRIAL_W-1:0] trial_ff, trial_in;
   logic [TRIAL_W-1:0] ttop_ff,  ttop_in;
   logic [TDEG_W-1:0]  tdeg_ff,  tdeg_in;
   logic [DATA_W-1:0]  rem_ff,   rem_in;
   logic [DATA_W-1:0]  quo_ff,   quo_in;
   logic [DATA_W-1:0]  div_ff,   div_in;
   logic [DEG_W-1:0]   idx_ff,   idx_in;

   logic [TRIAL_W:0]   trial_p1;
   logic               deg_wrap;
   logic [EXP_W-1:0]   deg_p1;
   logic [EXP_W-1:0]   lim_exp;
   logic [DEG_W-1:0]   shamt;
   logic               qbit;

   always_comb begin
      trial_p1 = {1'b0, trial_ff} + (TRIAL_W + 1)'(1);
      // trial + 1 is the next power of two: divisor degree steps up
      deg_wrap = (trial_p1 == {ttop_ff, 1'b0});
      deg_p1   = {1'b0, deg_ff} + EXP_W'(1);
      lim_exp  = {1'b0, deg_p1[EXP_W-1:1]} + EXP_W'(1);
      shamt    = deg_ff - DEG_W'(tdeg_ff);
      qbit     = rem_ff[idx_ff];

      sts.p_le1      = (poly_ff[DATA_W-1:1] == '0);
      sts.msb_set    = scan_ff[DATA_W-1];
      sts.div_last   = (idx_ff == DEG_W'(tdeg_ff));
      sts.hit        = (rem_ff == '0) && (quo_ff[DATA_W-1:1] != '0);
      sts.last_trial = deg_wrap && ((EXP_W'(tdeg_ff) + EXP_W'(1)) == lim_exp);
   end

   always_comb begin
      poly_in  = poly_ff;
      scan_in  = scan_ff;
      deg_in   = deg_ff;
      trial_in = trial_ff;
      ttop_in  = ttop_ff;
      tdeg_in  = tdeg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      idx_in   = idx_ff;

      if (cmd.load_input) begin
         poly_in = poly_value[DATA_W-1:0];
         scan_in = poly_value[DATA_W-1:0];
         deg_in  = DEG_W'(DATA_W - 1);
      end
      if (cmd.deg_shift) begin
         scan_in = {scan_ff[DATA_W-2:0], 1'b0};
         deg_in  = deg_ff - DEG_W'(1);
      end
      if (cmd.init_trial) begin
         trial_in = TRIAL_W'(2);
         ttop_in  = TRIAL_W'(2);
         tdeg_in  = TDEG_W'(1);
      end
      if (cmd.load_div) begin
         rem_in = poly_ff;
         quo_in = '0;
         // divisor aligned so its top bit sits at the polynomial's degree
         div_in = {{(DATA_W - TRIAL_W){1'b0}}, trial_ff} << shamt;
         idx_in = deg_ff;
      end
      if (cmd.div_step) begin
         rem_in = qbit ? (rem_ff ^ div_ff) : rem_ff;
         quo_in = {quo_ff[DATA_W-2:0], qbit};
         div_in = {1'b0, div_ff[DATA_W-1:1]};
         idx_in = idx_ff - DEG_W'(1);
      end
      if (cmd.next_trial) begin
         trial_in = trial_p1[TRIAL_W-1:0];
         if (deg_wrap) begin
            ttop_in = {ttop_ff[TRIAL_W-2:0], 1'b0};
            tdeg_in = tdeg_ff + TDEG_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      poly_ff  <= poly_in;
      scan_ff  <= scan_in;
      deg_ff   <= deg_in;
      trial_ff <= trial_in;
      ttop_ff  <= ttop_in;
      tdeg_ff  <= tdeg_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      idx_ff   <= idx_in;
   end

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (idx_ff >= DEG_W'(tdeg_ff)))
      else $error("division step below divisor degree");

   a_div_aligned: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> div_ff[idx_ff])
      else $error("divisor top bit not aligned with current bit");

   a_trial_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.load_div |-> (DEG_W'(tdeg_ff) <= deg_ff))
      else $error("trial divisor degree exceeds polynomial degree");

endmodule

FILE: rtl/gf2irr_ctrl.sv
// Controller: sequences degree scan, trials and divisions, and holds the result register.
module gf2irr_ctrl
   import gf2irr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_is_irreducible,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;
   logic      res_ff, res_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_flag_ff, rsp_flag_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      res_in      = res_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_flag_in  = rsp_flag_ff;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_input = 1'b1;
               state_in       = ST_FIND;
            end
         end
         ST_FIND: begin
            if (sts.p_le1) begin
               res_in   = 1'b0;
               state_in = ST_DONE;
            end else if (sts.msb_set) begin
               cmd.init_trial = 1'b1;
               state_in       = ST_LOAD;
            end else begin
               cmd.deg_shift = 1'b1;
            end
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.hit) begin
               res_in   = 1'b0;
               state_in = ST_DONE;
            end else if (sts.last_trial) begin
               res_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.next_trial = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_irreducible = rsp_flag_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside of completion");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_FIND))
      else $error("accepted word did not start a degree scan");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

endmodule

FILE: rtl/gf2_poly_irreducibility_test.sv
// Sequence: accept, degree scan down from bit 31, then per trial divisor t a load, division
// steps from bit d down to deg(t) and a check, then completion; d = degree of the polynomial.
// Zero and one skip the trials; the worst case (d = 31, irreducible) is set by the single
// shift-XOR division unit stepping one quotient bit per cycle.
// One word in flight; the next word is accepted while the result waits in its output register.
// Synchronous active-high reset returns the controller to idle with no result pending.
module gf2_poly_irreducibility_test
   import gf2irr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_poly_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_irreducible
);

   cmd_type cmd;
   sts_type sts;

   gf2irr_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_irreducible (rsp_is_irreducible),
      .cmd                (cmd),
      .sts                (sts)
   );

   gf2irr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .poly_value (req_poly_value),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

FILE: bench/testbench.sv
// Testbench for gf2_poly_irreducibility_test: random and directed polynomials vs a predictor.
`timescale 1ns / 1ps

module testbench
   import gf2irr_pkg::*;
();

   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int LONG_HOLD   = 400;

   typedef struct {
      logic [31:0] poly;
      int          gap;
   } poly_word_type;

   typedef struct {
      logic [31:0] poly;
      logic        irreducible;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_poly_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_irreducible;

   poly_word_type poly_backlog[$];
   verdict_type   expected_verdicts[$];
   verdict_type   head;
   verdict_type   fresh;
   poly_word_type next_word;
   logic        word_taken = 1'b0;
   int          gap_left = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   // receiver side
   logic        hold_trigger = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          quiet_left = 0;
   int          stall_roll;

   gf2_poly_irreducibility_test u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_poly_value     (req_poly_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_irreducible (rsp_is_irreducible)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int leading_bit(input logic [63:0] v);
      int idx;
      idx = 0;
      for (int i = 0; i < 64; i++)
         if (v[i]) idx = i;
      return idx;
   endfunction

   // Trial division by every t in [2, 2^((d+1)/2+1)); a hit needs a nonconstant quotient.
   function automatic logic predict_irreducible(input logic [31:0] poly);
      logic [63:0] p, t, rem, quo, limit;
      int          dp, dt, sh;
      logic        verdict;
      p = {32'd0, poly};
      if (DATA_W < 32)
         p = p & ((64'd1 << DATA_W) - 1);
      if (p <= 64'd1) return 1'b0;
      dp = leading_bit(p);
      limit = 64'd1 << ((dp + 1) / 2 + 1);
      verdict = 1'b1;
      for (t = 64'd2; t < limit; t++) begin
         dt = leading_bit(t);
         rem = p;
         quo = '0;
         while (rem != 0 && leading_bit(rem) >= dt) begin
            sh = leading_bit(rem) - dt;
            quo ^= 64'd1 << sh;
            rem ^= t << sh;
         end
         if (rem == 0 && quo > 64'd1) begin
            verdict = 1'b0;
            break;
         end
      end
      return verdict;
   endfunction

   function automatic logic [31:0] gf2_multiply(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] acc;
      acc = '0;
      for (int i = 0; i < 32; i++)
         if (b[i]) acc ^= {32'd0, a} << i;
      return acc[31:0];
   endfunction

   function automatic logic [31:0] poly_of_degree(input int deg);
      return (32'd1 << deg) | ($urandom & ((32'd1 << deg) - 32'd1));
   endfunction

   // Mostly cheap degrees; high degrees only as products with a small factor.
   function automatic logic [31:0] random_poly();
      int roll, fdeg;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 32'($urandom_range(0, 3));
      if (roll < 50) return poly_of_degree($urandom_range(1, 14));
      if (roll < 68) return poly_of_degree($urandom_range(15, 18));
      fdeg = $urandom_range(1, 4);
      return gf2_multiply(poly_of_degree(fdeg), poly_of_degree($urandom_range(24, 31 - fdeg)));
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic queue_word(input logic [31:0] poly, input int gap);
      poly_word_type entry;
      entry.poly = poly;
      entry.gap  = gap;
      poly_backlog = {poly_backlog, entry};
   endtask

   task automatic wait_drained();
      while (poly_backlog.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || word_taken) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (poly_backlog.size() > 0) begin
            next_word = poly_backlog.pop_front();
            req_valid      <= 1'b1;
            req_poly_value <= next_word.poly;
            gap_left       <= next_word.gap;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // accepted words get their verdict predicted here
   always @(posedge clock) begin
      word_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         fresh.poly        = req_poly_value;
         fresh.irreducible = predict_irreducible(req_poly_value);
         expected_verdicts = {expected_verdicts, fresh};
      end
   end

   // receiver stall pattern, plus one long hold on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_trigger && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (quiet_left > 0) begin
         rsp_stall  <= 1'b0;
         quiet_left <= quiet_left - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 10) begin
            rsp_stall  <= 1'b0;
            quiet_left <= $urandom_range(30, 80);
         end else if (stall_roll < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_roll < 95) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(20, 60);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("result %0b with no word outstanding", rsp_is_irreducible));
         end else begin
            head = expected_verdicts.pop_front();
            if (rsp_is_irreducible !== head.irreducible)
               report_mismatch($sformatf("poly %08h: is_irreducible %0b, want %0b",
                                         head.poly, rsp_is_irreducible, head.irreducible));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_verdicts.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      // zero, one, both degree-one polys, small cases, then the widest values
      queue_word(32'h0000_0000, 0);
      queue_word(32'h0000_0001, 0);
      queue_word(32'h0000_0002, 0);
      queue_word(32'h0000_0003, 0);
      queue_word(32'h0000_0004, 0);
      queue_word(32'h0000_0005, 0);
      queue_word(32'h0000_0006, 0);
      queue_word(32'h0000_0007, 0);
      queue_word(32'h0000_000B, 0);
      queue_word(32'h0000_0013, 0);
      queue_word(32'h0000_011B, 0);
      queue_word(32'h0001_002D, 0);
      queue_word(32'h0000_FFFF, 0);
      queue_word(32'hFFFF_FFFF, 0);
      queue_word(32'h8000_0000, 0);
      queue_word(32'h8000_0001, 0);
      queue_word(32'hAAAA_AAAA, 0);
      queue_word(32'h5555_5555, 0);
      queue_word(32'hFFFF_0000, 0);
      queue_word(gf2_multiply(32'h7, poly_of_degree(29)), 0);
      queue_word(gf2_multiply(32'h3, poly_of_degree(30)), 0);
      queue_word(gf2_multiply(32'hB, poly_of_degree(28)), 0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait_drained();

      // long receiver hold while quick words keep arriving
      hold_trigger = 1'b1;
      for (int i = 0; i < 8; i++)
         queue_word(32'($urandom_range(0, 3)), 0);

      for (int i = 0; i < 90; i++) begin
         if (i == 45)
            wait_drained();
         queue_word(random_poly(), pick_gap());
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
